// ===== src/four_channel_micro_dma_defines.svh =====
// Assertion macros used by the checker file of the block.
`ifndef FOUR_CHANNEL_MICRO_DMA_DEFINES_SVH
`define FOUR_CHANNEL_MICRO_DMA_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held.
`define FCMD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define FCMD_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/fcmd_pkg.sv =====
`timescale 1ns / 1ps

package fcmd_pkg;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_TRIGGER = 2'd2;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;
    localparam logic [1:0] SZ_LONG = 2'd2;
    localparam logic [1:0] SZ_NONE = 2'd3;

    localparam logic [7:0] REG_SHORT_FIRST = 8'h20;
    localparam logic [7:0] REG_SHORT_LAST  = 8'h2F;
    localparam logic [1:0] REG_MODE_LANE   = 2'h2;

    localparam logic [2:0] AM_DEST_UP   = 3'd0;
    localparam logic [2:0] AM_DEST_DOWN = 3'd1;
    localparam logic [2:0] AM_SRC_UP    = 3'd2;
    localparam logic [2:0] AM_SRC_DOWN  = 3'd3;
    localparam logic [2:0] AM_COUNTER   = 3'd5;

    localparam logic [4:0] INT_BASE = 5'd14;
    localparam logic [6:0] VEC_BASE = 7'h7C;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_ACCESS = 2'd0,
        KIND_COPY   = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_TRIGGER,
        CMD_NOP
    } t_cmd_kind;

    typedef enum logic [2:0] {
        TGT_SOURCE,
        TGT_DEST,
        TGT_COUNT,
        TGT_MODE,
        TGT_BAD
    } t_target;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  access_size;
        logic [7:0]  reg_address;
        logic [31:0] write_data;
        logic [1:0]  channel;
    } t_item;

    typedef struct packed {
        t_kind       result_kind;
        logic [31:0] read_data;
        logic        bad_register;
        logic [31:0] copy_source;
        logic [31:0] copy_dest;
        logic [1:0]  copy_size;
        logic [4:0]  interrupt_number;
        logic [6:0]  vector_address;
        logic        last_result;
    } t_result;

    typedef struct packed {
        t_cmd_kind   kind;
        t_target     target;
        logic [1:0]  channel;
        logic [31:0] data;
    } t_cmd;

endpackage

// ===== src/fcmd_front.sv =====
`timescale 1ns / 1ps

module fcmd_front #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fcmd_pkg::t_item i_item,
    input  logic           i_full,
    output logic           o_push,
    output fcmd_pkg::t_cmd  o_cmd
);
    import fcmd_pkg::*;

    logic       reg_chan_ok;
    logic [1:0] reg_chan;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;
    assign reg_chan   = i_item.reg_address[3:2];
    assign reg_chan_ok = (int'(reg_chan) < NUM_CHANNELS);

    always_comb begin
        o_cmd.kind    = CMD_NOP;
        o_cmd.target  = TGT_BAD;
        o_cmd.channel = i_item.channel;
        o_cmd.data    = i_item.write_data;
        case (i_item.operation) inside
            OP_WRITE, OP_READ: begin
                o_cmd.kind    = (i_item.operation == OP_WRITE) ? CMD_WRITE : CMD_READ;
                o_cmd.channel = reg_chan;
                if (reg_chan_ok) begin
                    if (i_item.access_size == SZ_LONG && i_item.reg_address < REG_SHORT_FIRST
                        && i_item.reg_address[1:0] == 2'b00) begin
                        o_cmd.target = i_item.reg_address[4] ? TGT_DEST : TGT_SOURCE;
                    end else if (i_item.access_size == SZ_WORD
                                 && i_item.reg_address >= REG_SHORT_FIRST
                                 && i_item.reg_address <= REG_SHORT_LAST
                                 && i_item.reg_address[1:0] == 2'b00) begin
                        o_cmd.target = TGT_COUNT;
                    end else if (i_item.access_size == SZ_BYTE
                                 && i_item.reg_address >= REG_SHORT_FIRST
                                 && i_item.reg_address <= REG_SHORT_LAST
                                 && i_item.reg_address[1:0] == REG_MODE_LANE) begin
                        o_cmd.target = TGT_MODE;
                    end
                end
            end
            OP_TRIGGER: begin
                if (int'(i_item.channel) < NUM_CHANNELS) begin
                    o_cmd.kind = CMD_TRIGGER;
                end
            end
            default: begin
                o_cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

// ===== src/fcmd_queue.sv =====
`timescale 1ns / 1ps

module fcmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fcmd_pkg::t_cmd  i_cmd,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output fcmd_pkg::t_cmd  o_cmd
);
    import fcmd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== src/fcmd_back.sv =====
`timescale 1ns / 1ps

module fcmd_back #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  fcmd_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output fcmd_pkg::t_result o_result
);
    import fcmd_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [31:0] r_src  [NUM_CHANNELS];
    logic [31:0] r_dst  [NUM_CHANNELS];
    logic [15:0] r_cnt  [NUM_CHANNELS];
    logic [7:0]  r_mode [NUM_CHANNELS];

    logic        r_out_valid;
    t_result     r_out;
    logic        r_pend;
    logic [1:0]  r_pend_ch;

    logic [CH_W-1:0] idx;
    logic [31:0]     cur_src;
    logic [31:0]     cur_dst;
    logic [15:0]     cur_cnt;
    logic [7:0]      cur_mode;
    logic [2:0]      am;
    logic [1:0]      sz;
    logic [31:0]     step;
    logic            can_load;
    logic            wr_src, wr_dst, wr_cnt, wr_mode;
    logic [31:0]     n_src;
    logic [31:0]     n_dst;
    logic [15:0]     n_cnt;
    logic [7:0]      n_mode;
    logic            n_pend;
    logic            done;
    t_result         n_res;

    function automatic t_result done_result(input logic [1:0] ch);
        t_result r;
        r = '0;
        r.result_kind      = KIND_DONE;
        r.interrupt_number = INT_BASE + 5'(ch);
        r.vector_address   = VEC_BASE + 7'(ch);
        r.last_result      = 1'b1;
        return r;
    endfunction

    assign idx      = i_cmd.channel[CH_W-1:0];
    assign cur_src  = r_src[idx];
    assign cur_dst  = r_dst[idx];
    assign cur_cnt  = r_cnt[idx];
    assign cur_mode = r_mode[idx];
    assign am       = cur_mode[4:2];
    assign sz       = cur_mode[1:0];
    assign step     = 32'd1 << sz;
    assign done     = (cur_cnt == 16'd1);

    assign can_load    = !r_out_valid || i_out_ready;
    assign o_pop       = i_valid && can_load && !r_pend;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        wr_src  = 1'b0;
        wr_dst  = 1'b0;
        wr_cnt  = 1'b0;
        wr_mode = 1'b0;
        n_src   = i_cmd.data;
        n_dst   = i_cmd.data;
        n_cnt   = i_cmd.data[15:0];
        n_mode  = i_cmd.data[7:0];
        n_pend  = 1'b0;
        n_res   = '0;
        n_res.result_kind = KIND_NONE;
        n_res.last_result = 1'b1;
        unique case (i_cmd.kind)
            CMD_WRITE: begin
                n_res.result_kind  = KIND_ACCESS;
                n_res.bad_register = (i_cmd.target == TGT_BAD);
                unique case (i_cmd.target)
                    TGT_SOURCE: wr_src  = 1'b1;
                    TGT_DEST:   wr_dst  = 1'b1;
                    TGT_COUNT:  wr_cnt  = 1'b1;
                    TGT_MODE:   wr_mode = 1'b1;
                    default:    wr_src  = 1'b0;
                endcase
            end
            CMD_READ: begin
                n_res.result_kind  = KIND_ACCESS;
                n_res.bad_register = (i_cmd.target == TGT_BAD);
                unique case (i_cmd.target)
                    TGT_SOURCE: n_res.read_data = cur_src;
                    TGT_DEST:   n_res.read_data = cur_dst;
                    TGT_COUNT:  n_res.read_data = {16'd0, cur_cnt};
                    TGT_MODE:   n_res.read_data = {24'd0, cur_mode};
                    default:    n_res.read_data = '0;
                endcase
            end
            CMD_TRIGGER: begin
                if (cur_cnt != 16'd0 && am <= AM_COUNTER) begin
                    wr_cnt = 1'b1;
                    n_cnt  = cur_cnt - 16'd1;
                    if (am == AM_COUNTER) begin
                        wr_src = 1'b1;
                        n_src  = cur_src + 32'd1;
                    end else if (sz != SZ_NONE) begin
                        unique case (am)
                            AM_DEST_UP: begin
                                wr_dst = 1'b1;
                                n_dst  = cur_dst + step;
                            end
                            AM_DEST_DOWN: begin
                                wr_dst = 1'b1;
                                n_dst  = cur_dst - step;
                            end
                            AM_SRC_UP: begin
                                wr_src = 1'b1;
                                n_src  = cur_src + step;
                            end
                            AM_SRC_DOWN: begin
                                wr_src = 1'b1;
                                n_src  = cur_src - step;
                            end
                            default: wr_src = 1'b0;
                        endcase
                    end
                    if (am != AM_COUNTER && sz != SZ_NONE) begin
                        n_res.result_kind = KIND_COPY;
                        n_res.copy_source = cur_src;
                        n_res.copy_dest   = cur_dst;
                        n_res.copy_size   = sz;
                        n_res.last_result = !done;
                        n_pend            = done;
                    end else if (done) begin
                        n_res = done_result(i_cmd.channel);
                    end
                end
            end
            default: begin
                n_res.result_kind = KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_src[i]  <= '0;
                r_dst[i]  <= '0;
                r_cnt[i]  <= '0;
                r_mode[i] <= '0;
            end
        end else begin
            if (r_pend && can_load) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else if (o_pop) begin
                r_out_valid <= 1'b1;
                r_pend      <= n_pend;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && wr_src) begin
                r_src[idx] <= n_src;
            end
            if (o_pop && wr_dst) begin
                r_dst[idx] <= n_dst;
            end
            if (o_pop && wr_cnt) begin
                r_cnt[idx] <= n_cnt;
            end
            if (o_pop && wr_mode) begin
                r_mode[idx] <= n_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && can_load) begin
            r_out <= done_result(r_pend_ch);
        end else if (o_pop) begin
            r_out     <= n_res;
            r_pend_ch <= i_cmd.channel;
        end
    end

endmodule

// ===== src/four_channel_micro_dma.sv =====
`timescale 1ns / 1ps
// Four-channel micro DMA controller.
// The input channel (i_in_valid, o_in_ready, i_item) carries one transaction per
// register write, register read or channel trigger. The output channel
// (o_out_valid, i_out_ready, o_result) returns one or two results for each
// transaction, in order, with last_result set on the final one.
// Accepted transactions are decoded and placed in a two-entry queue; the
// execution stage then takes one transaction per cycle from that queue while
// its output register is free. A result is loaded into the output register once
// its transaction has passed through the queue, and is held until the receiver
// takes it. Throughput is one transaction per cycle while the output is not
// stalled, except that a trigger which both copies and completes holds the queue
// until its second result is loaded, because the execution stage has a single output register.
// When the receiver holds i_out_ready low the result stays in the output
// register, the queue fills, and o_in_ready falls once both entries are used.
// A synchronous reset on i_rst_n empties the queue, drops any pending result
// and clears every channel's addresses, count and mode to zero.
module four_channel_micro_dma #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fcmd_pkg::t_item    i_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output fcmd_pkg::t_result  o_result
);
    import fcmd_pkg::*;

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic push;
    logic full;
    logic head_valid;
    logic pop;

    fcmd_front #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (i_item),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    fcmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .o_valid (head_valid),
        .i_pop   (pop),
        .o_cmd   (head_cmd)
    );

    fcmd_back #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

endmodule

// ===== src/fcmd_checker.sv =====
`timescale 1ns / 1ps
`include "four_channel_micro_dma_defines.svh"

module fcmd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input fcmd_pkg::t_result  o_result
);
    import fcmd_pkg::*;

    property p_out_hold;
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result);
    endproperty

    property p_copy_then_done;
        o_out_valid && i_out_ready && o_result.result_kind == KIND_COPY
            && !o_result.last_result |=> o_out_valid && o_result.result_kind == KIND_DONE;
    endproperty

    property p_done_fields;
        o_out_valid && o_result.result_kind == KIND_DONE |-> o_result.last_result
            && o_result.vector_address
               == 7'(o_result.interrupt_number) + (VEC_BASE - 7'(INT_BASE));
    endproperty

    property p_reset_clears;
        !i_rst_n |=> !o_out_valid;
    endproperty

    `FCMD_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "Result changed while stalled.")

    `FCMD_ASSERT(a_copy_then_done, i_clk, i_rst_n, p_copy_then_done, "Copy lost its completion.")

    `FCMD_ASSERT(a_done_fields, i_clk, i_rst_n, p_done_fields, "Completion fields disagree.")

    `FCMD_ASSERT_NR(a_reset_clears, i_clk, p_reset_clears, "Output valid after reset.")

endmodule

bind four_channel_micro_dma fcmd_checker u_fcmd_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import fcmd_pkg::*;

    localparam int NUM_CH       = 4;
    localparam int RANDOM_ITEMS = 730;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 20;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [7:0] REG_SRC_BASE  = 8'h00;
    localparam logic [7:0] REG_DST_BASE  = 8'h10;
    localparam logic [7:0] REG_CNT_BASE  = REG_SHORT_FIRST;
    localparam logic [7:0] REG_MODE_BASE = REG_SHORT_FIRST + 8'(REG_MODE_LANE);
    localparam logic [1:0] REG_WORD_LANE = 2'd0;

    localparam logic [2:0] AM_FIXED  = 3'd4;
    localparam logic [2:0] AM_BAD_LO = 3'd6;
    localparam logic [2:0] AM_BAD_HI = 3'd7;

    typedef struct {
        t_item       item;
        bit          typed;
        t_kind       kind;
        logic [31:0] rd;
        logic        bad;
    } t_row;

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_in_valid  = 1'b0;
    logic    o_in_ready;
    t_item   i_item      = '0;
    logic    o_out_valid;
    logic    i_out_ready = 1'b0;
    t_result o_result;

    logic [31:0] src_model   [NUM_CH];
    logic [31:0] dst_model   [NUM_CH];
    logic [15:0] count_model [NUM_CH];
    logic [7:0]  mode_model  [NUM_CH];

    t_result pending_results [$];
    t_row    directed [$];
    int      errors     = 0;
    int      items_sent = 0;
    bit      quiet      = 1'b0;
    bit      stall_req  = 1'b0;

    four_channel_micro_dma #(
        .NUM_CHANNELS(NUM_CH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (i_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_result   (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [7:0] src_reg(int n);
        return REG_SRC_BASE + 8'(4 * n);
    endfunction

    function automatic logic [7:0] dst_reg(int n);
        return REG_DST_BASE + 8'(4 * n);
    endfunction

    function automatic logic [7:0] cnt_reg(int n);
        return REG_CNT_BASE + 8'(4 * n);
    endfunction

    function automatic logic [7:0] mode_reg(int n);
        return REG_MODE_BASE + 8'(4 * n);
    endfunction

    function automatic logic [7:0] mode_byte(logic [2:0] am, logic [1:0] sz);
        return {3'b000, am, sz};
    endfunction

    function automatic t_item make_item(logic [1:0] op, logic [1:0] sz, logic [7:0] addr,
                                        logic [31:0] data, logic [1:0] ch);
        t_item it;
        it.operation   = op;
        it.access_size = sz;
        it.reg_address = addr;
        it.write_data  = data;
        it.channel     = ch;
        return it;
    endfunction

    function automatic t_row step_row(logic [1:0] op, logic [1:0] sz, logic [7:0] addr,
                                      logic [31:0] data, logic [1:0] ch);
        t_row r;
        r.item  = make_item(op, sz, addr, data, ch);
        r.typed = 1'b0;
        r.kind  = KIND_NONE;
        r.rd    = '0;
        r.bad   = 1'b0;
        return r;
    endfunction

    function automatic t_row known_row(logic [1:0] op, logic [1:0] sz, logic [7:0] addr,
                                       logic [31:0] data, logic [1:0] ch, t_kind kind,
                                       logic [31:0] rd, logic bad);
        t_row r;
        r.item  = make_item(op, sz, addr, data, ch);
        r.typed = 1'b1;
        r.kind  = kind;
        r.rd    = rd;
        r.bad   = bad;
        return r;
    endfunction

    function automatic t_item random_read(int ch);
        case ($urandom_range(0, 3))
            0:       return make_item(OP_READ, SZ_LONG, src_reg(ch), 32'($urandom), 2'(ch));
            1:       return make_item(OP_READ, SZ_LONG, dst_reg(ch), 32'($urandom), 2'(ch));
            2:       return make_item(OP_READ, SZ_WORD, cnt_reg(ch), 32'($urandom), 2'(ch));
            default: return make_item(OP_READ, SZ_BYTE, mode_reg(ch), 32'($urandom), 2'(ch));
        endcase
    endfunction

    function automatic logic [31:0] random_address();
        case ($urandom_range(0, 2))
            0:       return 32'($urandom_range(0, 15));
            1:       return 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic int draw_gap();
        if (quiet || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // Works out the results of one transaction and moves the channel state on.
    task automatic dma_predict(input t_item it, output t_result r0, output t_result r1,
                               output int n);
        t_result     blank;
        t_result     done;
        logic [1:0]  reg_ch;
        logic [1:0]  ch;
        logic [2:0]  am;
        logic [1:0]  sz;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] rd;
        logic [31:0] stride;
        bit          found;
        bit          in_short;
        bit          copy;
        blank             = '0;
        blank.last_result = 1'b1;
        r0                = blank;
        r1                = blank;
        n                 = 1;
        if (it.operation == OP_WRITE || it.operation == OP_READ) begin
            reg_ch   = it.reg_address[3:2];
            in_short = it.reg_address >= REG_SHORT_FIRST && it.reg_address <= REG_SHORT_LAST;
            found    = 1'b1;
            rd       = '0;
            if (int'(reg_ch) >= NUM_CH) begin
                found = 1'b0;
            end else if (it.access_size == SZ_LONG && it.reg_address < REG_SHORT_FIRST
                         && it.reg_address[1:0] == REG_WORD_LANE) begin
                if (it.reg_address[4]) begin
                    if (it.operation == OP_WRITE) dst_model[reg_ch] = it.write_data;
                    else rd = dst_model[reg_ch];
                end else begin
                    if (it.operation == OP_WRITE) src_model[reg_ch] = it.write_data;
                    else rd = src_model[reg_ch];
                end
            end else if (it.access_size == SZ_WORD && in_short
                         && it.reg_address[1:0] == REG_WORD_LANE) begin
                if (it.operation == OP_WRITE) count_model[reg_ch] = it.write_data[15:0];
                else rd = 32'(count_model[reg_ch]);
            end else if (it.access_size == SZ_BYTE && in_short
                         && it.reg_address[1:0] == REG_MODE_LANE) begin
                if (it.operation == OP_WRITE) mode_model[reg_ch] = it.write_data[7:0];
                else rd = 32'(mode_model[reg_ch]);
            end else begin
                found = 1'b0;
            end
            r0.result_kind  = KIND_ACCESS;
            r0.read_data    = rd;
            r0.bad_register = !found;
            return;
        end
        r0.result_kind = KIND_NONE;
        ch = it.channel;
        if (it.operation != OP_TRIGGER || int'(ch) >= NUM_CH || count_model[ch] == 16'd0) begin
            return;
        end
        am = mode_model[ch][4:2];
        sz = mode_model[ch][1:0];
        if (am > AM_COUNTER) begin
            return;
        end
        src  = src_model[ch];
        dst  = dst_model[ch];
        copy = 1'b0;
        if (am == AM_COUNTER) begin
            src_model[ch] = src + 32'd1;
        end else if (sz != SZ_NONE) begin
            copy   = 1'b1;
            stride = 32'd1 << sz;
            case (am)
                AM_DEST_UP:   dst_model[ch] = dst + stride;
                AM_DEST_DOWN: dst_model[ch] = dst - stride;
                AM_SRC_UP:    src_model[ch] = src + stride;
                AM_SRC_DOWN:  src_model[ch] = src - stride;
                default: ;
            endcase
        end
        count_model[ch] = count_model[ch] - 16'd1;
        n = 0;
        if (copy) begin
            r0             = blank;
            r0.result_kind = KIND_COPY;
            r0.copy_source = src;
            r0.copy_dest   = dst;
            r0.copy_size   = sz;
            r0.last_result = count_model[ch] != 16'd0;
            n = 1;
        end
        if (count_model[ch] == 16'd0) begin
            done                  = blank;
            done.result_kind      = KIND_DONE;
            done.interrupt_number = INT_BASE + 5'(ch);
            done.vector_address   = VEC_BASE + 7'(ch);
            if (n == 0) r0 = done;
            else r1 = done;
            n++;
        end
        if (n == 0) begin
            n = 1;
        end
    endtask

    task automatic send_item(input t_item it, input bit typed, input t_result want);
        t_result r0;
        t_result r1;
        int      n;
        int      gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_item     <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        dma_predict(it, r0, r1, n);
        if (typed) begin
            pending_results.push_back(want);
        end else begin
            pending_results.push_back(r0);
            if (n == 2) pending_results.push_back(r1);
        end
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Receiver side: accepts results with random hold-offs and checks each one.
    initial begin
        int      hold;
        t_result want;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (stall_req) begin
                hold      = LONG_HOLD;
                stall_req = 1'b0;
            end else begin
                hold = draw_gap();
            end
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, o_result);
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(o_result.result_kind));
                check_field("read_data", want.read_data, o_result.read_data);
                check_field("bad_register", 32'(want.bad_register), 32'(o_result.bad_register));
                check_field("copy_source", want.copy_source, o_result.copy_source);
                check_field("copy_dest", want.copy_dest, o_result.copy_dest);
                check_field("copy_size", 32'(want.copy_size), 32'(o_result.copy_size));
                check_field("interrupt_number", 32'(want.interrupt_number),
                            32'(o_result.interrupt_number));
                check_field("vector_address", 32'(want.vector_address),
                            32'(o_result.vector_address));
                check_field("last_result", 32'(want.last_result), 32'(o_result.last_result));
            end
        end
    end

    initial begin
        #1_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin
        t_result    want;
        t_item      it;
        int         ch;
        int         trigs;
        int         pick;
        logic [2:0] am;
        logic [1:0] sz;
        logic [15:0] cnt;
        bit         stalled_once;
        bit         drained_once;
        stalled_once = 1'b0;
        drained_once = 1'b0;
        for (int i = 0; i < NUM_CH; i++) begin
            src_model[i]   = '0;
            dst_model[i]   = '0;
            count_model[i] = '0;
            mode_model[i]  = '0;
        end

        directed = '{
            // After reset every register reads as zero and no channel has work; a source write then reads back.
            known_row(OP_READ, SZ_LONG, src_reg(0), 32'h0, 2'd0, KIND_ACCESS, 32'h0, 1'b0),
            known_row(OP_READ, SZ_BYTE, mode_reg(3), 32'h0, 2'd3, KIND_ACCESS, 32'h0, 1'b0),
            known_row(OP_TRIGGER, SZ_BYTE, 8'h00, 32'h0, 2'd0, KIND_NONE, 32'h0, 1'b0),
            known_row(OP_UNUSED, SZ_NONE, 8'hFF, 32'hFFFF_FFFF, 2'd3, KIND_NONE, 32'h0, 1'b0),
            known_row(OP_WRITE, SZ_LONG, src_reg(3), 32'hFFFF_FFFF, 2'd0, KIND_ACCESS,
                      32'h0, 1'b0),
            known_row(OP_READ, SZ_LONG, src_reg(3), 32'h0, 2'd0, KIND_ACCESS,
                      32'hFFFF_FFFF, 1'b0),
            // Accesses of the wrong size or outside the map are flagged.
            known_row(OP_WRITE, SZ_LONG, cnt_reg(0), 32'h1234_5678, 2'd0, KIND_ACCESS,
                      32'h0, 1'b1),
            known_row(OP_READ, SZ_BYTE, src_reg(0), 32'h0, 2'd0, KIND_ACCESS, 32'h0, 1'b1),
            known_row(OP_WRITE, SZ_NONE, dst_reg(0), 32'hFFFF_FFFF, 2'd0, KIND_ACCESS,
                      32'h0, 1'b1),
            known_row(OP_READ, SZ_LONG, 8'hFF, 32'h0, 2'd0, KIND_ACCESS, 32'h0, 1'b1),
            // Channel 0: one long transfer upwards that copies and completes at once.
            step_row(OP_WRITE, SZ_LONG, dst_reg(0), 32'hFFFF_FFFC, 2'd0),
            step_row(OP_WRITE, SZ_WORD, cnt_reg(0), 32'hFFFF_0001, 2'd0),
            step_row(OP_WRITE, SZ_BYTE, mode_reg(0),
                     32'hFFFF_FFE0 | 32'(mode_byte(AM_DEST_UP, SZ_LONG)), 2'd0),
            step_row(OP_TRIGGER, SZ_BYTE, 8'h00, 32'h0, 2'd0),
            step_row(OP_READ, SZ_LONG, dst_reg(0), 32'h0, 2'd0),
            // Channel 1: word copies downwards, wrapping below zero.
            step_row(OP_WRITE, SZ_WORD, cnt_reg(1), 32'h0000_FFFF, 2'd1),
            step_row(OP_WRITE, SZ_BYTE, mode_reg(1), 32'(mode_byte(AM_SRC_DOWN, SZ_WORD)), 2'd1),
            step_row(OP_TRIGGER, SZ_BYTE, 8'h00, 32'h0, 2'd1),
            step_row(OP_READ, SZ_LONG, src_reg(1), 32'h0, 2'd1),
            // Channel 2: counter mode steps the source without a copy.
            step_row(OP_WRITE, SZ_WORD, cnt_reg(2), 32'h2, 2'd2),
            step_row(OP_WRITE, SZ_BYTE, mode_reg(2), 32'(mode_byte(AM_COUNTER, SZ_LONG)), 2'd2),
            step_row(OP_TRIGGER, SZ_BYTE, 8'h00, 32'h0, 2'd2),
            step_row(OP_TRIGGER, SZ_BYTE, 8'h00, 32'h0, 2'd2),
            // Channel 3: a bad mode, then fixed addressing with nothing to copy.
            step_row(OP_WRITE, SZ_WORD, cnt_reg(3), 32'h2, 2'd3),
            step_row(OP_WRITE, SZ_BYTE, mode_reg(3), 32'(mode_byte(AM_BAD_HI, SZ_NONE)), 2'd3),
            step_row(OP_TRIGGER, SZ_BYTE, 8'h00, 32'h0, 2'd3),
            step_row(OP_WRITE, SZ_BYTE, mode_reg(3), 32'(mode_byte(AM_FIXED, SZ_NONE)), 2'd3),
            step_row(OP_TRIGGER, SZ_BYTE, 8'h00, 32'h0, 2'd3),
            step_row(OP_TRIGGER, SZ_BYTE, 8'h00, 32'h0, 2'd3)
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            want             = '0;
            want.result_kind = directed[k].kind;
            want.read_data   = directed[k].rd;
            want.bad_register = directed[k].bad;
            want.last_result = 1'b1;
            send_item(directed[k].item, directed[k].typed, want);
        end

        want = '0;
        while (items_sent < directed.size() + RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 7) == 0);
            if (!stalled_once && items_sent > 250) begin
                // The receiver holds off while transactions keep coming.
                stall_req    = 1'b1;
                quiet        = 1'b1;
                stalled_once = 1'b1;
            end
            if (!drained_once && items_sent > 450) begin
                wait_drained();
                drained_once = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                ch  = $urandom_range(0, NUM_CH - 1);
                am  = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(AM_BAD_LO, AM_BAD_HI))
                                                   : 3'($urandom_range(0, AM_COUNTER));
                sz  = 2'($urandom_range(0, 3));
                cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 5));
                send_item(make_item(OP_WRITE, SZ_LONG, src_reg(ch), random_address(),
                                    2'($urandom)), 1'b0, want);
                send_item(make_item(OP_WRITE, SZ_LONG, dst_reg(ch), random_address(),
                                    2'($urandom)), 1'b0, want);
                send_item(make_item(OP_WRITE, SZ_WORD, cnt_reg(ch), {16'($urandom), cnt},
                                    2'($urandom)), 1'b0, want);
                send_item(make_item(OP_WRITE, SZ_BYTE, mode_reg(ch),
                                    {24'($urandom), 3'($urandom), am, sz}, 2'($urandom)),
                          1'b0, want);
                trigs = ((cnt > 16'd6) ? 6 : int'(cnt)) + $urandom_range(0, 1);
                repeat (trigs) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_item(random_read(ch), 1'b0, want);
                    end
                    it = make_item(OP_TRIGGER, 2'($urandom), 8'($urandom), 32'($urandom),
                                   2'(ch));
                    if ($urandom_range(0, 7) == 0) it.channel = 2'($urandom);
                    send_item(it, 1'b0, want);
                end
            end else if (pick < 8) begin
                send_item(random_read($urandom_range(0, NUM_CH - 1)), 1'b0, want);
            end else begin
                send_item(make_item(2'($urandom), 2'($urandom), 8'($urandom), 32'($urandom),
                                    2'($urandom)), 1'b0, want);
            end
        end
        quiet = 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
